FILE: hdl/distance_vector_route_table_assert.svh
// Assertion helpers for the route table block.
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_ASSERT_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_ASSERT_SVH

// cond must hold in the cycle after trig held
`define DVRT_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("assertion failed");

// cond must hold on every cycle out of reset
`define DVRT_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

`endif

FILE: hdl/dvrt_pkg.sv
`timescale 1ns / 1ps
package dvrt_pkg;
  localparam int MAX_NODES = 16;
  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam logic [7:0] INF_RESET = 8'd99;
  localparam logic [CNT_W-1:0] NODES_RESET = CNT_W'(MAX_NODES);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_QUERY = 1'b1;
  localparam logic REG_NODE_COUNT = 1'b0;
  localparam logic REG_INFINITY = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [3:0] row;
    logic [3:0] col;
    logic [7:0] link_cost;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic [3:0] next_hop;
    logic [7:0] distance;
    logic       reachable;
    logic       ready_res;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE, S_QUERY, S_INIT_RD, S_INIT_WR, S_REL_IJ, S_REL_BEST,
    S_REL_RD, S_REL_CMP, S_REL_WR
  } state_t;

  typedef struct packed {
    logic              cost_we;
    logic              q_capture;
    logic              q_out;
    logic              init_wr;
    logic              best_load;
    logic              cmp;
    logic              rel_wr;
    logic              self_k;
    logic [IDX_W-1:0]  hop_val;
    logic [ADDR_W-1:0] cost_raddr;
    logic [ADDR_W-1:0] dist_raddr;
    logic [ADDR_W-1:0] waddr;
    logic              tables_ready;
  } dvrt_cmd_t;

  typedef struct packed {
    logic             upd;
    logic             out_busy;
    logic [IDX_W-1:0] nm1;
  } dvrt_stat_t;
endpackage

FILE: hdl/dvrt_ctrl.sv
`timescale 1ns / 1ps
module dvrt_ctrl import dvrt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_word_t   in_data,
  input  dvrt_stat_t stat,
  output dvrt_cmd_t  cmd
);
  state_t state, state_next;
  logic [IDX_W-1:0] i, i_next, j, j_next, k, k_next;
  logic pass_changed, pass_changed_next;
  logic tables_ready, tables_ready_next;
  logic acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      i <= '0;
      j <= '0;
      k <= '0;
      pass_changed <= 1'b0;
      tables_ready <= 1'b0;
    end else begin
      state <= state_next;
      i <= i_next;
      j <= j_next;
      k <= k_next;
      pass_changed <= pass_changed_next;
      tables_ready <= tables_ready_next;
    end
  end

  assign in_ready = (state == S_IDLE);
  assign acc = in_valid && in_ready;

  always_comb begin
    state_next = state;
    i_next = i;
    j_next = j;
    k_next = k;
    pass_changed_next = pass_changed;
    tables_ready_next = tables_ready;
    cmd = '0;
    cmd.tables_ready = tables_ready;
    cmd.cost_raddr = {i, j};
    cmd.dist_raddr = {i, j};
    cmd.waddr = {i, j};
    cmd.hop_val = j;
    case (state)
      S_IDLE: begin
        cmd.dist_raddr = {in_data.row, in_data.col};
        if (acc) begin
          if (in_data.operation == OP_LOAD) begin
            cmd.cost_we = 1'b1;
            tables_ready_next = 1'b0;
            if (in_data.last) begin
              i_next = '0;
              j_next = '0;
              state_next = S_INIT_RD;
            end
          end else begin
            cmd.q_capture = 1'b1;
            // keep the query address so a stalled result rereads the same entry
            i_next = in_data.row;
            j_next = in_data.col;
            state_next = S_QUERY;
          end
        end
      end
      S_QUERY: begin
        // hold the result until the output register frees up
        if (!stat.out_busy) begin
          cmd.q_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_INIT_RD: state_next = S_INIT_WR;
      S_INIT_WR: begin
        cmd.init_wr = 1'b1;
        if (j == stat.nm1) begin
          j_next = '0;
          if (i == stat.nm1) begin
            i_next = '0;
            pass_changed_next = 1'b0;
            state_next = S_REL_IJ;
          end else begin
            i_next = i + 1'b1;
            state_next = S_INIT_RD;
          end
        end else begin
          j_next = j + 1'b1;
          state_next = S_INIT_RD;
        end
      end
      S_REL_IJ: state_next = S_REL_BEST;
      S_REL_BEST: begin
        cmd.best_load = 1'b1;
        k_next = '0;
        state_next = S_REL_RD;
      end
      S_REL_RD: begin
        cmd.cost_raddr = {i, k};
        cmd.dist_raddr = {k, j};
        state_next = S_REL_CMP;
      end
      S_REL_CMP: begin
        cmd.cmp = 1'b1;
        cmd.hop_val = k;
        cmd.self_k = (k == i);
        if (k == stat.nm1) begin
          state_next = S_REL_WR;
        end else begin
          k_next = k + 1'b1;
          state_next = S_REL_RD;
        end
      end
      S_REL_WR: begin
        cmd.rel_wr = 1'b1;
        state_next = S_REL_IJ;
        if (j == stat.nm1) begin
          j_next = '0;
          if (i == stat.nm1) begin
            i_next = '0;
            // another pass only if this one improved something
            if (pass_changed || stat.upd) begin
              pass_changed_next = 1'b0;
            end else begin
              tables_ready_next = 1'b1;
              state_next = S_IDLE;
            end
          end else begin
            i_next = i + 1'b1;
            pass_changed_next = pass_changed || stat.upd;
          end
        end else begin
          j_next = j + 1'b1;
          pass_changed_next = pass_changed || stat.upd;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

FILE: hdl/dvrt_datapath.sv
`timescale 1ns / 1ps
module dvrt_datapath import dvrt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  in_word_t   in_data,
  input  dvrt_cmd_t  cmd,
  output dvrt_stat_t stat,
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_word_t  out_data
);
  localparam int CELLS = MAX_NODES * MAX_NODES;

  logic [7:0] cost_mem [CELLS];
  logic [7:0] dist_mem [CELLS];
  logic [IDX_W-1:0] hop_mem [CELLS];

  logic [7:0] cost_q, dist_q, best;
  logic [IDX_W-1:0] hop_q, best_hop;
  logic upd;
  logic [CNT_W-1:0] node_count;
  logic [7:0] infinity;
  logic [IDX_W-1:0] qrow, qcol;
  logic [CNT_W-1:0] n_use;
  logic [7:0] cost_cap, other, via, qdist;
  logic [8:0] sum;
  logic q_ok, q_reach;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODES_RESET;
      infinity <= INF_RESET;
    end else if (cfg_write) begin
      if (cfg_index == REG_NODE_COUNT) node_count <= cfg_data[CNT_W-1:0];
      else infinity <= cfg_data;
    end
  end

  always_comb begin
    n_use = node_count;
    if (node_count == '0) n_use = CNT_W'(1);
    else if (node_count > CNT_W'(MAX_NODES)) n_use = CNT_W'(MAX_NODES);
  end
  assign stat.nm1 = IDX_W'(n_use - 1'b1);
  assign stat.upd = upd;
  assign stat.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.cost_we) cost_mem[{in_data.row, in_data.col}] <= in_data.link_cost;
    cost_q <= cost_mem[cmd.cost_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.init_wr) begin
      dist_mem[cmd.waddr] <= cost_cap;
      hop_mem[cmd.waddr] <= cmd.hop_val;
    end else if (cmd.rel_wr && upd) begin
      dist_mem[cmd.waddr] <= best;
      hop_mem[cmd.waddr] <= best_hop;
    end
    dist_q <= dist_mem[cmd.dist_raddr];
    hop_q <= hop_mem[cmd.dist_raddr];
  end

  assign cost_cap = (cost_q > infinity) ? infinity : cost_q;
  // the entry under relaxation lives in best, not in memory
  assign other = cmd.self_k ? best : dist_q;
  assign sum = {1'b0, cost_cap} + {1'b0, other};
  assign via = (sum > {1'b0, infinity}) ? infinity : sum[7:0];

  always_ff @(posedge clk) begin
    if (cmd.best_load) begin
      best <= dist_q;
      upd <= 1'b0;
    end else if (cmd.cmp && (best > via)) begin
      best <= via;
      best_hop <= cmd.hop_val;
      upd <= 1'b1;
    end
    if (cmd.q_capture) begin
      qrow <= in_data.row;
      qcol <= in_data.col;
    end
  end

  assign q_ok = cmd.tables_ready && (qrow <= stat.nm1) && (qcol <= stat.nm1);
  assign qdist = q_ok ? ((dist_q > infinity) ? infinity : dist_q) : infinity;
  assign q_reach = q_ok && (qdist < infinity);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.q_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_out) begin
      out_data.next_hop <= q_reach ? hop_q : '0;
      out_data.distance <= qdist;
      out_data.reachable <= q_reach;
      out_data.ready_res <= cmd.tables_ready;
    end
  end
endmodule

FILE: hdl/distance_vector_route_table.sv
// A load word writes its link cost into the cost store. A query reads its entry
// into registers, then registers it at the output, held while it stalls; no new
// query is taken before that. A last-marked load runs the table build: an init
// sweep, then passes until one changes nothing; input is held off meanwhile.
// Each store has one read port. Synchronous reset clears control, node_count to
// 16 and infinity to 99; the cost, distance and next-hop stores are not cleared.
`timescale 1ns / 1ps
`include "distance_vector_route_table_assert.svh"
module distance_vector_route_table import dvrt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data,
  input  logic      cfg_write,
  input  logic      cfg_index,
  input  logic [7:0] cfg_data
);
  dvrt_cmd_t cmd;
  dvrt_stat_t stat;

  dvrt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .stat(stat), .cmd(cmd)
  );

  dvrt_datapath u_dp (
    .clk(clk), .rst(rst), .in_data(in_data), .cmd(cmd), .stat(stat),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  `DVRT_ASSERT_NEXT(a_load_clears, in_valid && in_ready && in_data.operation == OP_LOAD, !cmd.tables_ready)
  `DVRT_ASSERT_ALWAYS(a_one_write, $onehot0({cmd.cost_we, cmd.init_wr, cmd.rel_wr, cmd.q_out}))
  `DVRT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
endmodule
